// ----- rtl/sfp_diag_eeprom_slave_top_defines.svh -----
// Assertion macros for the pluggable-module EEPROM emulation checker.
// Depends on nothing; included by the checker file by its bare name.
`ifndef SFP_DIAG_EEPROM_SLAVE_TOP_DEFINES_SVH
`define SFP_DIAG_EEPROM_SLAVE_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define SFPDE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfpde check failed");

// Next-cycle implication, switched off while reset is asserted.
`define SFPDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfpde check failed");

`endif

// ----- rtl/sfpde_pkg.sv -----
// Shared types, codes and constants of the SFP EEPROM emulation.
// Has no dependencies; every other file but the macro header refers to it by scoped names.
`timescale 1ns / 1ps

package sfpde_pkg;

	// Page geometry
	localparam int PAGE_BYTES = 256;
	localparam int PTR_W      = $clog2(PAGE_BYTES);
	localparam int LIVE_WORDS = 5;

	// Slave addresses
	localparam logic [6:0] ADDR_ID   = 7'h50;
	localparam logic [6:0] ADDR_DIAG = 7'h51;

	// Diagnostics page offsets that are driven by live values
	localparam logic [7:0] LIVE_FIRST   = 8'd96;
	localparam logic [7:0] LIVE_LAST    = 8'd105;
	localparam logic [7:0] READY_BYTE   = 8'd110;
	localparam logic [7:0] FLAGS_A      = 8'd112;
	localparam logic [7:0] FLAGS_B      = 8'd113;
	localparam logic [7:0] FLAGS_A_COPY = 8'd116;
	localparam logic [7:0] FLAGS_B_COPY = 8'd117;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_SET_PTR = 2'd1,
		OP_READ    = 2'd2
	} opcode_t;

	typedef enum logic {
		STATUS_OK        = 1'b0,
		STATUS_NO_DEVICE = 1'b1
	} status_t;

	typedef logic [15:0] live_words_t [LIVE_WORDS];

	// Live-byte lookup result handed from the snapshot block to the top level
	typedef struct packed {
		logic       hit;
		logic [7:0] value;
	} live_rd_t;

	// True for diagnostics offsets whose contents come from live values.
	function automatic logic is_live_byte(input logic [7:0] off);
		return ((off >= LIVE_FIRST) && (off <= LIVE_LAST)) || (off == READY_BYTE) ||
			(off == FLAGS_A) || (off == FLAGS_B) ||
			(off == FLAGS_A_COPY) || (off == FLAGS_B_COPY);
	endfunction

endpackage

// ----- rtl/sfpde_page_ram.sv -----
// One 256-byte page image: single write port, single registered read port.
// Depends on sfpde_pkg for the page depth.
`timescale 1ns / 1ps

module sfpde_page_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [sfpde_pkg::PTR_W-1:0] waddr,
	input  logic [7:0]                 wdata,
	input  logic                       re,
	input  logic [sfpde_pkg::PTR_W-1:0] raddr,
	output logic [7:0]                 rdata
);

	logic [7:0] mem [sfpde_pkg::PAGE_BYTES];
	logic [7:0] rdata_q;

	// Contents are undefined until loaded, so there is no reset here.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/sfpde_live_snap.sv -----
// Snapshot of the live diagnostic words and alarm flags, and the byte view
// of them at the diagnostics pointer. Depends on sfpde_pkg.
`timescale 1ns / 1ps

module sfpde_live_snap (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    capture,
	input  sfpde_pkg::live_words_t  words,
	input  logic [9:0]              flags,
	input  logic [7:0]              offset,
	output sfpde_pkg::live_rd_t     live_rd
);

	sfpde_pkg::live_words_t words_q;
	logic [9:0]             flags_q;
	sfpde_pkg::live_words_t words_cur;
	logic [9:0]             flags_cur;
	logic [7:0]             rel;
	logic [2:0]             word_idx;
	logic [15:0]            word_sel;

	// Capture on the first diagnostics read of a message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sfpde_pkg::LIVE_WORDS; i++) begin
				words_q[i] <= '0;
			end
			flags_q <= '0;
		end else if (capture) begin
			words_q <= words;
			flags_q <= flags;
		end
	end

	// The read that captures sees the freshly captured values.
	always_comb begin
		words_cur = capture ? words : words_q;
		flags_cur = capture ? flags : flags_q;
	end

	// Select the word, then the big-endian byte within it.
	assign rel      = offset - sfpde_pkg::LIVE_FIRST;
	assign word_idx = rel[3:1];

	always_comb begin
		case (word_idx)
			3'd0:    word_sel = words_cur[0];
			3'd1:    word_sel = words_cur[1];
			3'd2:    word_sel = words_cur[2];
			3'd3:    word_sel = words_cur[3];
			3'd4:    word_sel = words_cur[4];
			default: word_sel = '0;
		endcase
	end

	// Byte value for any live offset; the data-ready byte always reads zero.
	always_comb begin
		live_rd.hit = sfpde_pkg::is_live_byte(offset);
		if ((offset >= sfpde_pkg::LIVE_FIRST) && (offset <= sfpde_pkg::LIVE_LAST)) begin
			live_rd.value = rel[0] ? word_sel[7:0] : word_sel[15:8];
		end else if ((offset == sfpde_pkg::FLAGS_A) || (offset == sfpde_pkg::FLAGS_A_COPY)) begin
			live_rd.value = flags_cur[9:2];
		end else if ((offset == sfpde_pkg::FLAGS_B) || (offset == sfpde_pkg::FLAGS_B_COPY)) begin
			live_rd.value = {flags_cur[1:0], 6'b0};
		end else begin
			live_rd.value = '0;
		end
	end

endmodule

// ----- rtl/sfp_diag_eeprom_slave_top.sv -----
// Top level of the two-slave pluggable-module EEPROM emulation.
// Depends on sfpde_pkg, sfpde_page_ram and sfpde_live_snap.
//
//  Channel   Handshake        Payload
//  --------  ---------------  ------------------------------------------------
//  command   start / busy     opcode, slave_address, load_offset, data_byte,
//                             first_in_message, five live words, alarm_flags
//  result    done (strobe)    read_data, status
//
// One transaction is taken in every cycle; busy is held low.
// Each result reaches the done strobe through the stage-1 register and the result
// register, the page memories' registered read port being read alongside stage 1.
// Reset clears both pointers and the live snapshot; page contents are
// undefined until loaded and have no clearing pass.
// The receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps

module sfp_diag_eeprom_slave_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [6:0]  slave_address,
	input  logic [7:0]  load_offset,
	input  logic [7:0]  data_byte,
	input  logic        first_in_message,
	input  logic [15:0] temperature_word,
	input  logic [15:0] supply_voltage_word,
	input  logic [15:0] tx_bias_word,
	input  logic [15:0] tx_power_word,
	input  logic [15:0] rx_power_word,
	input  logic [9:0]  alarm_flags,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        status
);

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_ID,
		KIND_DIAG
	} kind_t;

	logic                   accept;
	logic                   is_id;
	logic                   is_diag;
	logic                   op_load;
	logic                   op_set;
	logic                   op_read;
	logic                   load_id;
	logic                   load_diag;
	logic                   read_id;
	logic                   read_diag;
	logic                   capture;
	logic [sfpde_pkg::PTR_W-1:0] id_ptr_q;
	logic [sfpde_pkg::PTR_W-1:0] diag_ptr_q;
	logic [7:0]             id_rdata;
	logic [7:0]             diag_rdata;
	sfpde_pkg::live_words_t words;
	sfpde_pkg::live_rd_t    live_rd;
	kind_t                  kind;
	sfpde_pkg::status_t     status_now;

	logic                   valid_s1;
	kind_t                  kind_s1;
	sfpde_pkg::live_rd_t    live_s1;
	sfpde_pkg::status_t     status_s1;

	logic                   done_q;
	logic [7:0]             read_data_q;
	sfpde_pkg::status_t     status_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Command decode
	assign is_id   = (slave_address == sfpde_pkg::ADDR_ID);
	assign is_diag = (slave_address == sfpde_pkg::ADDR_DIAG);

	always_comb begin
		op_load = 1'b0;
		op_set  = 1'b0;
		op_read = 1'b0;
		unique case (opcode)
			sfpde_pkg::OP_LOAD:    op_load = 1'b1;
			sfpde_pkg::OP_SET_PTR: op_set  = 1'b1;
			sfpde_pkg::OP_READ:    op_read = 1'b1;
			default: ;
		endcase
	end

	assign load_id   = accept && is_id && op_load;
	assign load_diag = accept && is_diag && op_load && !sfpde_pkg::is_live_byte(load_offset);
	assign read_id   = accept && is_id && op_read;
	assign read_diag = accept && is_diag && op_read;
	assign capture   = read_diag && first_in_message;

	always_comb begin
		if (read_id) begin
			kind = KIND_ID;
		end else if (read_diag) begin
			kind = KIND_DIAG;
		end else begin
			kind = KIND_NONE;
		end
		status_now = (is_id || is_diag) ? sfpde_pkg::STATUS_OK : sfpde_pkg::STATUS_NO_DEVICE;
	end

	// Page pointers: set by a pointer command, advanced by each read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_ptr_q   <= '0;
			diag_ptr_q <= '0;
		end else begin
			if (accept && is_id && op_set) begin
				id_ptr_q <= data_byte;
			end else if (read_id) begin
				id_ptr_q <= id_ptr_q + 1'b1;
			end
			if (accept && is_diag && op_set) begin
				diag_ptr_q <= data_byte;
			end else if (read_diag) begin
				diag_ptr_q <= diag_ptr_q + 1'b1;
			end
		end
	end

	// Page memories
	sfpde_page_ram u_id_page (
		.clk   (clk),
		.we    (load_id),
		.waddr (load_offset),
		.wdata (data_byte),
		.re    (read_id),
		.raddr (id_ptr_q),
		.rdata (id_rdata)
	);

	sfpde_page_ram u_diag_page (
		.clk   (clk),
		.we    (load_diag),
		.waddr (load_offset),
		.wdata (data_byte),
		.re    (read_diag),
		.raddr (diag_ptr_q),
		.rdata (diag_rdata)
	);

	// Live values
	always_comb begin
		words[0] = temperature_word;
		words[1] = supply_voltage_word;
		words[2] = tx_bias_word;
		words[3] = tx_power_word;
		words[4] = rx_power_word;
	end

	sfpde_live_snap u_live (
		.clk     (clk),
		.arst_n  (arst_n),
		.capture (capture),
		.words   (words),
		.flags   (alarm_flags),
		.offset  (diag_ptr_q),
		.live_rd (live_rd)
	);

	// Stage 1: command taken, memory read under way.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1   <= kind;
		live_s1   <= live_rd;
		status_s1 <= status_now;
	end

	// Result register: merge memory data with the live byte view.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_s1;
		case (kind_s1)
			KIND_ID:   read_data_q <= id_rdata;
			KIND_DIAG: read_data_q <= live_s1.hit ? live_s1.value : diag_rdata;
			default:   read_data_q <= '0;
		endcase
	end

	assign done      = done_q;
	assign read_data = read_data_q;
	assign status    = status_q;

endmodule

// ----- rtl/sfpde_checker.sv -----
// Port-level checks of the EEPROM emulation, bound to its top level.
// Depends on sfpde_pkg and the macros in sfp_diag_eeprom_slave_top_defines.svh.
`timescale 1ns / 1ps
`include "sfp_diag_eeprom_slave_top_defines.svh"

module sfpde_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [6:0] slave_address,
	input logic       done,
	input logic [7:0] read_data,
	input logic       status
);

	// Every transaction taken gives exactly one result on the done strobe.
	`SFPDE_ASSERT_NEXT(a_result_follows, clk, arst_n, start && !busy, ##1 done)
	`SFPDE_ASSERT_IMPLY(a_no_spurious_result, clk, arst_n, done, $past(start && !busy, 2))

	// An unknown slave reports no-device and returns zero data.
	`SFPDE_ASSERT_IMPLY(a_no_device_status, clk, arst_n,
		done && $past(slave_address, 2) != sfpde_pkg::ADDR_ID &&
		$past(slave_address, 2) != sfpde_pkg::ADDR_DIAG,
		status == sfpde_pkg::STATUS_NO_DEVICE && read_data == 8'd0)

	// A known slave never reports no-device.
	`SFPDE_ASSERT_IMPLY(a_known_slave_ok, clk, arst_n,
		done && ($past(slave_address, 2) == sfpde_pkg::ADDR_ID ||
		$past(slave_address, 2) == sfpde_pkg::ADDR_DIAG),
		status == sfpde_pkg::STATUS_OK)

endmodule

bind sfp_diag_eeprom_slave_top sfpde_checker u_sfpde_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.slave_address (slave_address),
	.done          (done),
	.read_data     (read_data),
	.status        (status)
);
